FILE: design/asc_pkg.sv
// ----------------------------------------------------------------------------
// asc_pkg
// Shared types and constants for the Annex B start code splitter.
// ----------------------------------------------------------------------------
package asc_pkg;

    localparam int QDEPTH = 4;                 // command queue entries
    localparam int QAW    = $clog2(QDEPTH);    // queue pointer width
    localparam int QCW    = $clog2(QDEPTH + 1);// queue fill count width

    localparam logic [7:0] BYTE_ZERO = 8'h00;
    localparam logic [7:0] BYTE_ONE  = 8'h01;
    localparam logic [4:0] TYPE_MASK = 5'h1F;
    localparam logic [1:0] ZRUN_MAX  = 2'd3;

    // One classified input byte: the work the back end has to carry out.
    // Order of operations: nzero zero bytes, then data (if has_byte),
    // then close of the current unit, then the awaiting-first update.
    typedef struct packed {
        logic [2:0] nzero;
        logic       has_byte;
        logic [7:0] data;
        logic       close;
        logic       await_set;
        logic       await_clr;
    } t_cmd;

endpackage

FILE: design/annexb_start_code_splitter.sv
// ----------------------------------------------------------------------------
// annexb_start_code_splitter
// Splits an Annex B byte stream into unit payload bytes tagged with the
// unit type and first/end marks.
//
//   channel   dir  handshake           payload
//   input     in   i_valid / o_ready   i_stream_byte, i_buffer_end
//   result    out  o_valid / i_ready   o_payload_byte, o_unit_type,
//                                      o_unit_first, o_unit_end, o_run_last
//
// One byte per clock is accepted while each byte needs at most one back-end
// operation and the output is not stalled. The back end runs a byte's
// released zeros, byte, unit close in turn, at most one result each.
// A 4-entry command queue lets the input keep moving while the back end or
// the result register is stalled. Synchronous active-low reset, no clearing
// pass; o_ready is low during reset and the first byte can be taken in the
// cycle after reset is released.
// ----------------------------------------------------------------------------
module annexb_start_code_splitter
    import asc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_stream_byte,
    input  logic       i_buffer_end,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_payload_byte,
    output logic [4:0] o_unit_type,
    output logic       o_unit_first,
    output logic       o_unit_end,
    output logic       o_run_last
);

    logic push;
    logic space;
    logic pop;
    logic head_valid;
    t_cmd push_cmd;
    t_cmd head_cmd;

    asc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_stream_byte (i_stream_byte),
        .i_buffer_end  (i_buffer_end),
        .i_space       (space),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    asc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_space (space),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_cmd   (head_cmd)
    );

    asc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (head_valid),
        .i_cmd          (head_cmd),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_payload_byte (o_payload_byte),
        .o_unit_type    (o_unit_type),
        .o_unit_first   (o_unit_first),
        .o_unit_end     (o_unit_end),
        .o_run_last     (o_run_last)
    );

endmodule

FILE: design/asc_front.sv
// ----------------------------------------------------------------------------
// asc_front
// Input side: tracks the zero run and start codes and turns each input byte
// into one command for the back end.
// ----------------------------------------------------------------------------
module asc_front
    import asc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_stream_byte,
    input  logic       i_buffer_end,
    input  logic       i_space,
    output logic       o_push,
    output t_cmd       o_cmd
);

    logic [1:0] r_zero_run, n_zero_run;
    logic       r_inside, n_inside;

    logic [1:0] zr_mid;
    logic [2:0] nz;
    logic       has;
    logic       start;

    // no transfer while reset is held
    assign o_ready = i_space & i_rst_n;
    assign o_push  = i_valid & o_ready;

    always_comb begin
        zr_mid = r_zero_run;
        nz     = 3'd0;
        has    = 1'b0;
        start  = 1'b0;
        if (i_stream_byte == BYTE_ZERO) begin
            if (r_zero_run != ZRUN_MAX) begin
                zr_mid = r_zero_run + 2'd1;
            end else begin
                nz = 3'd1;  // oldest zero of a long run becomes payload
            end
        end else if (i_stream_byte == BYTE_ONE && r_zero_run[1]) begin
            start  = 1'b1;
            zr_mid = 2'd0;
        end else begin
            nz     = {1'b0, r_zero_run};
            has    = 1'b1;
            zr_mid = 2'd0;
        end
        // buffer end flushes whatever zeros are still held
        if (i_buffer_end) begin
            nz = nz + {1'b0, zr_mid};
        end

        o_cmd.nzero     = r_inside ? nz : 3'd0;
        o_cmd.has_byte  = r_inside & has;
        o_cmd.data      = i_stream_byte;
        o_cmd.close     = start | i_buffer_end;
        o_cmd.await_set = start & ~i_buffer_end;
        o_cmd.await_clr = i_buffer_end;

        n_zero_run = i_buffer_end ? 2'd0 : zr_mid;
        n_inside   = i_buffer_end ? 1'b0 : (start | r_inside);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_run <= 2'd0;
            r_inside   <= 1'b0;
        end else if (o_push) begin
            r_zero_run <= n_zero_run;
            r_inside   <= n_inside;
        end
    end

endmodule

FILE: design/asc_fifo.sv
// ----------------------------------------------------------------------------
// asc_fifo
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
module asc_fifo
    import asc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_space,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd           r_mem [QDEPTH];
    logic [QAW-1:0] r_wr_ptr;
    logic [QAW-1:0] r_rd_ptr;
    logic [QCW-1:0] r_count;

    assign o_space = (r_count != QCW'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QAW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QAW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - QCW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

FILE: design/asc_back.sv
// ----------------------------------------------------------------------------
// asc_back
// Output side: runs each command one operation per cycle against the held
// payload byte and drives the result register, waiting while it is stalled.
// ----------------------------------------------------------------------------
module asc_back
    import asc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cmd_valid,
    input  t_cmd       i_cmd,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_payload_byte,
    output logic [4:0] o_unit_type,
    output logic       o_unit_first,
    output logic       o_unit_end,
    output logic       o_run_last
);

    // per-command progress
    logic [2:0] r_zdone, n_zdone;
    logic       r_bdone, n_bdone;
    // unit state
    logic       r_held_valid, n_held_valid;
    logic       r_held_first, n_held_first;
    logic       r_awaiting, n_awaiting;
    logic [7:0] r_held_byte, n_held_byte;
    logic [4:0] r_type, n_type;
    // result register
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic [4:0] r_out_type;
    logic       r_out_first;
    logic       r_out_end;
    logic       r_out_last;

    logic       op_zero, op_byte, op_close, op_acc;
    logic [7:0] acc_x;
    logic       is_final;
    logic       emits;
    logic       go;

    always_comb begin
        op_zero  = i_cmd_valid && (r_zdone < i_cmd.nzero);
        op_byte  = i_cmd_valid && !op_zero && i_cmd.has_byte && !r_bdone;
        op_close = i_cmd_valid && !op_zero && !op_byte && i_cmd.close;
        op_acc   = op_zero | op_byte;
        acc_x    = op_zero ? BYTE_ZERO : i_cmd.data;

        if (op_zero) begin
            is_final = (r_zdone + 3'd1 == i_cmd.nzero) && !i_cmd.has_byte && !i_cmd.close;
        end else if (op_byte) begin
            is_final = !i_cmd.close;
        end else begin
            is_final = 1'b1;
        end

        // every op after an accumulate emits, so a final emitting op ends the run
        emits = (op_acc | op_close) & r_held_valid;
        go    = i_cmd_valid && (!emits || !r_out_valid || i_ready);
        o_pop = go & is_final;

        n_held_valid = r_held_valid;
        n_held_first = r_held_first;
        n_held_byte  = r_held_byte;
        n_awaiting   = r_awaiting;
        n_type       = r_type;
        if (op_acc) begin
            n_held_valid = 1'b1;
            n_held_byte  = acc_x;
            if (r_awaiting) begin
                n_type       = acc_x[4:0] & TYPE_MASK;
                n_held_first = 1'b1;
                n_awaiting   = 1'b0;
            end else begin
                n_held_first = 1'b0;
            end
        end
        if (op_close) begin
            n_held_valid = 1'b0;
            n_held_first = 1'b0;
        end
        if (is_final) begin
            if (i_cmd.await_set) begin
                n_awaiting = 1'b1;
            end
            if (i_cmd.await_clr) begin
                n_awaiting = 1'b0;
            end
        end

        n_zdone = is_final ? 3'd0 : (op_zero ? r_zdone + 3'd1 : r_zdone);
        n_bdone = is_final ? 1'b0 : (op_byte | r_bdone);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zdone      <= 3'd0;
            r_bdone      <= 1'b0;
            r_held_valid <= 1'b0;
            r_held_first <= 1'b0;
            r_awaiting   <= 1'b0;
            r_type       <= 5'd0;
            r_out_valid  <= 1'b0;
        end else begin
            if (go) begin
                r_zdone      <= n_zdone;
                r_bdone      <= n_bdone;
                r_held_valid <= n_held_valid;
                r_held_first <= n_held_first;
                r_awaiting   <= n_awaiting;
                r_type       <= n_type;
            end
            if (go && emits) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_held_byte <= n_held_byte;
        end
        if (go && emits) begin
            r_out_byte  <= r_held_byte;
            r_out_type  <= r_type;
            r_out_first <= r_held_first;
            r_out_end   <= op_close;
            r_out_last  <= is_final;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_payload_byte = r_out_byte;
    assign o_unit_type    = r_out_type;
    assign o_unit_first   = r_out_first;
    assign o_unit_end     = r_out_end;
    assign o_run_last     = r_out_last;

`ifndef SYNTHESIS
    a_first_needs_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_first |-> r_held_valid)
        else $error("held byte marked first without a held byte");

    a_awaiting_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_awaiting |-> !r_held_valid)
        else $error("byte held while waiting for a unit's first byte");

    a_zero_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_zdone != 3'd0 |-> (i_cmd_valid && (r_zdone <= i_cmd.nzero)))
        else $error("zero progress count beyond its command");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready && r_held_valid && i_cmd_valid &&
         (r_zdone < i_cmd.nzero || i_cmd.has_byte || i_cmd.close)) |-> !o_pop)
        else $error("command retired while its result could not be stored");
`endif

endmodule
